// ===== hdl/brb_pkg.sv =====
`timescale 1ns / 1ps

package brb_pkg;

  localparam int FUNC_W  = 2;
  localparam int TAG_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 2;
  localparam int AVAIL_W = 11;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH = 2'd0,
    FN_READ = 2'd1,
    FN_PEEK = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR,
    ST_OUT,
    ST_RC_RD,
    ST_RC_LD,
    ST_DIV
  } state_t;

endpackage

// ===== hdl/brb_ifs.sv =====
`timescale 1ns / 1ps

interface brb_in_if;
  import brb_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TAG_W-1:0]  reader_tag;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output func, output reader_tag, output rx_byte, input ready);
  modport sink (input valid, input func, input reader_tag, input rx_byte, output ready);
endinterface

interface brb_out_if;
  import brb_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [BYTE_W-1:0]  data_byte;
  logic [AVAIL_W-1:0] available_count;

  modport source (output valid, output status, output data_byte, output available_count,
                  input ready);
  modport sink (input valid, input status, input data_byte, input available_count,
                output ready);
endinterface

// ===== hdl/broadcast_ring_buffer_multi_reader_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Words
// in_ch     in   func, reader_tag, rx_byte
// out_ch    out  status, data_byte, available_count
// cfg       in   cfg_wr_data (buffer_size), cfg_wr_en
//
// Each word is accepted with a cursor RAM read, then ST_CUR does the ring
// RAM read/write and cursor write-back; when the output register is free, the
// next word is taken while the result loads into the output register.
// A buffer_size write rebuilds the head and every reader position with a
// bit-serial remainder, input held off meanwhile.
// rst is synchronous; the ring and reader table hold no reset contents.

module broadcast_ring_buffer_multi_reader_unit #(
  parameter int DEPTH       = 1024,
  parameter int MAX_READERS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  brb_in_if.sink                in_ch,
  brb_out_if.source             out_ch,
  input  logic                  cfg_wr_en,
  input  logic [brb_pkg::CFG_W-1:0] cfg_wr_data
);
  import brb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);
  localparam int RW = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CW = $clog2(MAX_READERS + 1);
  localparam int EW = CNT_W + AW;

  state_t state, state_next;

  logic [CNT_W-1:0] wc, wc_next;
  logic [AW-1:0]    wr_pos, wr_pos_next;
  logic [SW-1:0]    size, size_next;
  logic [CW-1:0]    rd_count, rd_count_next;
  logic [TAG_W-1:0] tags [MAX_READERS];

  logic [FUNC_W-1:0] it_func, it_func_next;
  logic [TAG_W-1:0]  it_tag, it_tag_next;
  logic [BYTE_W-1:0] it_byte, it_byte_next;
  logic [RW-1:0]     it_slot, it_slot_next;
  logic              it_hit, it_hit_next;
  logic              it_full, it_full_next;
  logic [CNT_W-1:0]  oldest, oldest_next;

  status_t          res_status, res_status_next;
  logic [SW-1:0]    res_avail, res_avail_next;
  logic             res_rd, res_rd_next;

  logic              out_valid, out_valid_next;
  logic [STAT_W-1:0] out_status, out_status_next;
  logic [BYTE_W-1:0] out_data, out_data_next;
  logic [AVAIL_W-1:0] out_avail, out_avail_next;

  logic [CNT_W-1:0] div_num, div_num_next;
  logic [SW-1:0]    div_rem, div_rem_next;
  logic [4:0]       div_cnt, div_cnt_next;
  logic             rc_wc, rc_wc_next;
  logic [CW-1:0]    rc_idx, rc_idx_next;
  logic [CNT_W-1:0] rc_cur, rc_cur_next;

  logic [BYTE_W-1:0] ring [DEPTH];
  logic [BYTE_W-1:0] ring_q;
  logic              ring_we, ring_re;
  logic [AW-1:0]     ring_raddr;

  logic [EW-1:0] cmem [MAX_READERS];
  logic [EW-1:0] cm_q, cm_wdata;
  logic          cm_we, cm_re;
  logic [RW-1:0] cm_waddr, cm_raddr;
  logic          tag_we;

  logic          accept, out_free;
  logic          hit;
  logic [RW-1:0] midx;

  logic [CNT_W-1:0] cur, cur_c;
  logic [AW-1:0]    pos, pos_c;
  logic [SW-1:0]    pinc, winc;
  logic [SW:0]      rem_sh, rem_new;
  logic [CNT_W-1:0] cfg_ext;

  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) || ((state == ST_OUT) && out_free);
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid;
  assign out_ch.status          = out_status;
  assign out_ch.data_byte       = out_data;
  assign out_ch.available_count = out_avail;

  always_comb begin
    hit  = 1'b0;
    midx = '0;
    for (int i = MAX_READERS - 1; i >= 0; i--) begin
      if ((CW'(i) < rd_count) && (tags[i] == in_ch.reader_tag)) begin
        hit  = 1'b1;
        midx = RW'(i);
      end
    end
  end

  assign cur     = cm_q[EW-1:AW];
  assign pos     = cm_q[AW-1:0];
  assign winc    = SW'(wr_pos) + SW'(1);
  assign rem_sh  = {div_rem, div_num[CNT_W-1]};
  assign rem_new = (rem_sh >= {1'b0, size}) ? (rem_sh - {1'b0, size}) : rem_sh;
  assign cfg_ext = CNT_W'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    wc_next         = wc;
    wr_pos_next     = wr_pos;
    size_next       = size;
    rd_count_next   = rd_count;
    it_func_next    = it_func;
    it_tag_next     = it_tag;
    it_byte_next    = it_byte;
    it_slot_next    = it_slot;
    it_hit_next     = it_hit;
    it_full_next    = it_full;
    oldest_next     = oldest;
    res_status_next = res_status;
    res_avail_next  = res_avail;
    res_rd_next     = res_rd;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_avail_next  = out_avail;
    div_num_next    = div_num;
    div_rem_next    = div_rem;
    div_cnt_next    = div_cnt;
    rc_wc_next      = rc_wc;
    rc_idx_next     = rc_idx;
    rc_cur_next     = rc_cur;
    ring_we         = 1'b0;
    ring_re         = 1'b0;
    ring_raddr      = wr_pos;
    cm_we           = 1'b0;
    cm_re           = 1'b0;
    cm_waddr        = it_slot;
    cm_raddr        = it_slot;
    cm_wdata        = {wc, wr_pos};
    tag_we          = 1'b0;
    cur_c           = cur;
    pos_c           = pos;
    pinc            = '0;

    if (out_valid && out_ch.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
      end
      ST_CUR: begin
        res_status_next = STAT_OK;
        res_avail_next  = '0;
        res_rd_next     = 1'b0;
        case (it_func)
          FN_PUSH: begin
            ring_we = 1'b1;
            wc_next = wc + CNT_W'(1);
            if (wc == {CNT_W{1'b1}}) begin
              wr_pos_next = '0;
            end else if (winc >= size) begin
              wr_pos_next = '0;
            end else begin
              wr_pos_next = AW'(winc);
            end
          end
          FN_READ, FN_PEEK: begin
            if (it_full) begin
              res_status_next = STAT_FULL;
            end else if (!it_hit) begin
              tag_we          = 1'b1;
              rd_count_next   = rd_count + CW'(1);
              cm_we           = 1'b1;
              cm_wdata        = {wc, wr_pos};
              res_status_next = STAT_EMPTY;
            end else if (cur >= wc) begin
              res_status_next = STAT_EMPTY;
            end else begin
              if (cur < oldest) begin
                cur_c = oldest;
                pos_c = wr_pos;
              end
              res_avail_next = SW'(wc - cur_c);
              res_rd_next    = 1'b1;
              ring_re        = 1'b1;
              ring_raddr     = pos_c;
              if (it_func == FN_READ) begin
                pinc = SW'(pos_c) + SW'(1);
                cur_c = cur_c + CNT_W'(1);
                pos_c = (pinc >= size) ? '0 : AW'(pinc);
              end
              cm_we    = 1'b1;
              cm_wdata = {cur_c, pos_c};
            end
          end
          default: begin
          end
        endcase
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_data_next   = res_rd ? ring_q : '0;
          out_avail_next  = AVAIL_W'(res_avail);
          state_next      = ST_IDLE;
        end
      end
      ST_RC_RD: begin
        cm_re      = 1'b1;
        cm_raddr   = rc_idx[RW-1:0];
        state_next = ST_RC_LD;
      end
      ST_RC_LD: begin
        div_num_next = cur;
        rc_cur_next  = cur;
        div_rem_next = '0;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        div_num_next = div_num << 1;
        div_rem_next = SW'(rem_new);
        div_cnt_next = div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          if (rc_wc) begin
            wr_pos_next = AW'(rem_new);
            rc_idx_next = '0;
          end else begin
            cm_we       = 1'b1;
            cm_waddr    = rc_idx[RW-1:0];
            cm_wdata    = {rc_cur, AW'(rem_new)};
            rc_idx_next = rc_idx + CW'(1);
          end
          rc_wc_next = 1'b0;
          state_next = (rc_idx_next < rd_count) ? ST_RC_RD : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (accept) begin
      it_func_next = in_ch.func;
      it_tag_next  = in_ch.reader_tag;
      it_byte_next = in_ch.rx_byte;
      it_hit_next  = hit;
      it_full_next = !hit && (rd_count == CW'(MAX_READERS));
      it_slot_next = hit ? midx : rd_count[RW-1:0];
      oldest_next  = (wc > CNT_W'(size)) ? (wc - CNT_W'(size)) : '0;
      cm_re        = 1'b1;
      cm_raddr     = hit ? midx : rd_count[RW-1:0];
      state_next   = ST_CUR;
    end

    if (cfg_wr_en) begin
      if (cfg_ext == '0) begin
        size_next = SW'(1);
      end else if (cfg_ext > CNT_W'(DEPTH)) begin
        size_next = SW'(DEPTH);
      end else begin
        size_next = SW'(cfg_ext);
      end
      rc_wc_next   = 1'b1;
      div_num_next = wc;
      div_rem_next = '0;
      div_cnt_next = '0;
      state_next   = ST_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wc        <= '0;
      wr_pos    <= '0;
      size      <= SW'(DEPTH);
      rd_count  <= '0;
      out_valid <= 1'b0;
    end else begin
      wc        <= wc_next;
      wr_pos    <= wr_pos_next;
      size      <= size_next;
      rd_count  <= rd_count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    it_func    <= it_func_next;
    it_tag     <= it_tag_next;
    it_byte    <= it_byte_next;
    it_slot    <= it_slot_next;
    it_hit     <= it_hit_next;
    it_full    <= it_full_next;
    oldest     <= oldest_next;
    res_status <= res_status_next;
    res_avail  <= res_avail_next;
    res_rd     <= res_rd_next;
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_avail  <= out_avail_next;
    div_num    <= div_num_next;
    div_rem    <= div_rem_next;
    div_cnt    <= div_cnt_next;
    rc_wc      <= rc_wc_next;
    rc_idx     <= rc_idx_next;
    rc_cur     <= rc_cur_next;
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tags[it_slot] <= it_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_pos] <= it_byte;
    end
    if (ring_re) begin
      ring_q <= ring[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cm_q <= cmem[cm_raddr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rd_count <= CW'(MAX_READERS))
    else $error("reader count past table size");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CUR))
    else $error("accepted word did not enter cursor stage");

  a_cur_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CUR) |=> (state == ST_OUT))
    else $error("cursor stage not followed by output stage");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (SW'(wr_pos) < size))
    else $error("head position outside ring size");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> ((state == ST_DIV) && rc_wc && !in_ch.ready))
    else $error("size write did not start head rebuild");

endmodule
